// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and held off
// during active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property.
`define PVA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pva assertion failed");

// Same-cycle implication.
`define PVA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  `PVA_ASSERT(label, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define PVA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  `PVA_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

// ===== rtl/core/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// Types and constants shared by the voice allocator modules and interfaces.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned SOUND_W      = 16;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned AGE_W        = 32;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned LIVE_FIELD_W = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START    = 2'd0,
    ACT_STOP     = 2'd1,
    ACT_STOP_ALL = 2'd2,
    ACT_FINISH   = 2'd3
  } action_e;

  typedef struct packed {
    logic [SOUND_W-1:0] sound;
    logic [PRIO_W-1:0]  prio;
    logic [AGE_W-1:0]   age;
  } pva_entry_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic publish;
  } pva_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } pva_sts_t;

endpackage

// ===== rtl/core/pva_req_if.sv =====
// ----------------------------------------------------------------------------
// pva_req_if
// Request channel: one voice event item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pva_req_if;
  import pva_pkg::*;

  logic                valid;
  logic                ready;
  action_e             action;
  logic [SOUND_W-1:0]  sound_id;
  logic [PRIO_W-1:0]   priority_req;
  logic                playable;
  logic                music_duck;
  logic [SLOT_FIELD_W-1:0] slot;

  modport source (
    output valid, action, sound_id, priority_req, playable, music_duck, slot,
    input  ready
  );

  modport sink (
    input  valid, action, sound_id, priority_req, playable, music_duck, slot,
    output ready
  );
endinterface

// ===== rtl/core/pva_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pva_rsp_if
// Result channel: one allocation result item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pva_rsp_if;
  import pva_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    granted;
  logic [SLOT_FIELD_W-1:0] granted_slot;
  logic                    stole;
  logic [LIVE_FIELD_W-1:0] live_count;
  logic                    any_ducking;
  logic [TOTAL_W-1:0]      drop_total;
  logic [TOTAL_W-1:0]      steal_total;

  modport source (
    output valid, granted, granted_slot, stole, live_count, any_ducking,
           drop_total, steal_total,
    input  ready
  );

  modport sink (
    input  valid, granted, granted_slot, stole, live_count, any_ducking,
           drop_total, steal_total,
    output ready
  );
endinterface

// ===== rtl/core/pva_ctrl.sv =====
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer: accept an item, run the slot scan, commit, publish the result.
// ----------------------------------------------------------------------------
module pva_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  pva_pkg::pva_sts_t sts_i,
  output pva_pkg::pva_cmd_t cmd_o
);
  import pva_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   accept;

  assign accept      = (state_q == S_IDLE) && ready_q && req_valid_i;
  assign req_ready_o = ready_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = accept;
    cmd_o.commit  = (state_q == S_COMMIT);
    cmd_o.publish = (state_q == S_DONE) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_SCAN;
            ready_q <= 1'b0;
          end else begin
            ready_q <= 1'b1;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pva_datapath.sv =====
// ----------------------------------------------------------------------------
// pva_datapath
// Slot table, scan pipeline, steal selection, counters and result register.
// ----------------------------------------------------------------------------
module pva_datapath #(
  parameter int unsigned VOICE_SLOTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pva_pkg::pva_cmd_t                 cmd_i,
  output pva_pkg::pva_sts_t                 sts_o,
  input  pva_pkg::action_e                  req_action_i,
  input  logic [pva_pkg::SOUND_W-1:0]       req_sound_id_i,
  input  logic [pva_pkg::PRIO_W-1:0]        req_priority_i,
  input  logic                              req_playable_i,
  input  logic                              req_music_duck_i,
  input  logic [pva_pkg::SLOT_FIELD_W-1:0]  req_slot_i,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic                              rsp_granted_o,
  output logic [pva_pkg::SLOT_FIELD_W-1:0]  rsp_granted_slot_o,
  output logic                              rsp_stole_o,
  output logic [pva_pkg::LIVE_FIELD_W-1:0]  rsp_live_count_o,
  output logic                              rsp_any_ducking_o,
  output logic [pva_pkg::TOTAL_W-1:0]       rsp_drop_total_o,
  output logic [pva_pkg::TOTAL_W-1:0]       rsp_steal_total_o
);
  import pva_pkg::*;

  localparam int unsigned AW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(VOICE_SLOTS + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(VOICE_SLOTS - 1);

  // captured item
  action_e               act_q;
  logic [SOUND_W-1:0]    sound_q;
  logic [PRIO_W-1:0]     prio_q;
  logic                  play_q;
  logic                  duck_in_q;
  logic [SLOT_FIELD_W-1:0] fin_q;

  // per-slot flags
  logic [VOICE_SLOTS-1:0] live_q, live_d;
  logic [VOICE_SLOTS-1:0] fading_q, fading_d;
  logic [VOICE_SLOTS-1:0] ducks_q, ducks_d;

  // slot table
  pva_entry_t mem_q [VOICE_SLOTS];
  pva_entry_t rd_q;
  logic       mem_we;
  logic [AW-1:0] mem_wa;
  pva_entry_t mem_wd;

  // scan pipeline
  logic          issue_q;
  logic [AW-1:0] idx_q;
  logic          proc_v_q;
  logic [AW-1:0] proc_idx_q;

  // selection
  logic              free_found_q, free_found_d;
  logic [AW-1:0]     free_idx_q, free_idx_d;
  logic              best_found_q, best_found_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic [PRIO_W-1:0] best_prio_q, best_prio_d;
  logic [AGE_W-1:0]  best_age_q, best_age_d;

  // counters
  logic [CW-1:0]      live_cnt_q, live_cnt_d;
  logic [CW-1:0]      duck_cnt_q, duck_cnt_d;
  logic [AGE_W-1:0]   start_cnt_q, start_cnt_d;
  logic [TOTAL_W-1:0] drop_cnt_q, drop_cnt_d;
  logic [TOTAL_W-1:0] steal_cnt_q, steal_cnt_d;

  // per-item result
  logic          res_granted_q, res_granted_d;
  logic [AW-1:0] res_slot_q, res_slot_d;
  logic          res_stole_q, res_stole_d;

  // result register
  logic                    rsp_valid_q;
  logic                    rsp_granted_q;
  logic [SLOT_FIELD_W-1:0] rsp_slot_q;
  logic                    rsp_stole_q;
  logic [LIVE_FIELD_W-1:0] rsp_live_q;
  logic                    rsp_duck_q;
  logic [TOTAL_W-1:0]      rsp_drop_q;
  logic [TOTAL_W-1:0]      rsp_steal_q;

  logic          p_live, p_fade, p_duck;
  logic          cand, stop_hit;
  logic [AW-1:0] grant_idx;
  logic          grant_ok, grant_old_duck;
  logic          fin_ok;
  logic [AW-1:0] fin_idx;
  logic          fin_duck;

  assign p_live = live_q[proc_idx_q];
  assign p_fade = fading_q[proc_idx_q];
  assign p_duck = ducks_q[proc_idx_q];

  assign cand = (rd_q.prio <= prio_q) &&
                (!best_found_q || (rd_q.prio < best_prio_q) ||
                 ((rd_q.prio == best_prio_q) && (rd_q.age < best_age_q)));
  assign stop_hit = p_live && ((act_q == ACT_STOP_ALL) || (rd_q.sound == sound_q));

  assign grant_idx      = free_found_q ? free_idx_q : best_idx_q;
  assign grant_ok       = play_q && (free_found_q || best_found_q);
  assign grant_old_duck = live_q[grant_idx] & ~fading_q[grant_idx] & ducks_q[grant_idx];

  assign fin_ok   = (32'(fin_q) < VOICE_SLOTS);
  assign fin_idx  = AW'(fin_q);
  assign fin_duck = live_q[fin_idx] & ~fading_q[fin_idx] & ducks_q[fin_idx];

  assign sts_o.scan_done = proc_v_q && (proc_idx_q == LAST_IDX);
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    live_d       = live_q;
    fading_d     = fading_q;
    ducks_d      = ducks_q;
    live_cnt_d   = live_cnt_q;
    duck_cnt_d   = duck_cnt_q;
    start_cnt_d  = start_cnt_q;
    drop_cnt_d   = drop_cnt_q;
    steal_cnt_d  = steal_cnt_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_age_d   = best_age_q;
    res_granted_d = res_granted_q;
    res_slot_d    = res_slot_q;
    res_stole_d   = res_stole_q;
    mem_we        = 1'b0;
    mem_wa        = grant_idx;
    mem_wd.sound  = sound_q;
    mem_wd.prio   = prio_q;
    mem_wd.age    = start_cnt_q + AGE_W'(1);

    if (cmd_i.capture) begin
      free_found_d = 1'b0;
      best_found_d = 1'b0;
    end

    if (proc_v_q) begin
      case (act_q)
        ACT_START: begin
          if (!p_live && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = proc_idx_q;
          end
          if (p_live && cand) begin
            best_found_d = 1'b1;
            best_idx_d   = proc_idx_q;
            best_prio_d  = rd_q.prio;
            best_age_d   = rd_q.age;
          end
        end
        ACT_STOP, ACT_STOP_ALL: begin
          if (stop_hit) begin
            fading_d[proc_idx_q] = 1'b1;
            if (!p_fade && p_duck) begin
              duck_cnt_d = duck_cnt_q - CW'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.commit) begin
      res_granted_d = 1'b0;
      res_slot_d    = '0;
      res_stole_d   = 1'b0;
      case (act_q)
        ACT_START: begin
          if (grant_ok) begin
            mem_we              = 1'b1;
            live_d[grant_idx]   = 1'b1;
            fading_d[grant_idx] = 1'b0;
            ducks_d[grant_idx]  = duck_in_q;
            start_cnt_d         = start_cnt_q + AGE_W'(1);
            duck_cnt_d          = duck_cnt_q - CW'(grant_old_duck) + CW'(duck_in_q);
            if (free_found_q) begin
              live_cnt_d = live_cnt_q + CW'(1);
            end else begin
              steal_cnt_d = steal_cnt_q + TOTAL_W'(1);
              res_stole_d = 1'b1;
            end
            res_granted_d = 1'b1;
            res_slot_d    = grant_idx;
          end else begin
            drop_cnt_d = drop_cnt_q + TOTAL_W'(1);
          end
        end
        ACT_FINISH: begin
          if (fin_ok) begin
            if (live_q[fin_idx]) begin
              live_cnt_d = live_cnt_q - CW'(1);
              duck_cnt_d = duck_cnt_q - CW'(fin_duck);
            end
            live_d[fin_idx]   = 1'b0;
            fading_d[fin_idx] = 1'b0;
            ducks_d[fin_idx]  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // slot table, one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (issue_q) begin
      rd_q <= mem_q[idx_q];
    end
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  // item and selection payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q     <= req_action_i;
      sound_q   <= req_sound_id_i;
      prio_q    <= req_priority_i;
      play_q    <= req_playable_i;
      duck_in_q <= req_music_duck_i;
      fin_q     <= req_slot_i;
    end
    free_idx_q    <= free_idx_d;
    best_idx_q    <= best_idx_d;
    best_prio_q   <= best_prio_d;
    best_age_q    <= best_age_d;
    res_granted_q <= res_granted_d;
    res_slot_q    <= res_slot_d;
    res_stole_q   <= res_stole_d;
    proc_idx_q    <= idx_q;
    if (cmd_i.publish) begin
      rsp_granted_q <= res_granted_q;
      rsp_slot_q    <= SLOT_FIELD_W'(res_slot_q);
      rsp_stole_q   <= res_stole_q;
      rsp_live_q    <= LIVE_FIELD_W'(live_cnt_q);
      rsp_duck_q    <= (duck_cnt_q != '0);
      rsp_drop_q    <= drop_cnt_q;
      rsp_steal_q   <= steal_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q       <= '0;
      fading_q     <= '0;
      ducks_q      <= '0;
      live_cnt_q   <= '0;
      duck_cnt_q   <= '0;
      start_cnt_q  <= '0;
      drop_cnt_q   <= '0;
      steal_cnt_q  <= '0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      issue_q      <= 1'b0;
      idx_q        <= '0;
      proc_v_q     <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      live_q       <= live_d;
      fading_q     <= fading_d;
      ducks_q      <= ducks_d;
      live_cnt_q   <= live_cnt_d;
      duck_cnt_q   <= duck_cnt_d;
      start_cnt_q  <= start_cnt_d;
      drop_cnt_q   <= drop_cnt_d;
      steal_cnt_q  <= steal_cnt_d;
      free_found_q <= free_found_d;
      best_found_q <= best_found_d;
      proc_v_q     <= issue_q;
      if (cmd_i.capture) begin
        issue_q <= 1'b1;
        idx_q   <= '0;
      end else if (issue_q) begin
        idx_q <= idx_q + AW'(1);
        if (idx_q == LAST_IDX) begin
          issue_q <= 1'b0;
        end
      end
      if (cmd_i.publish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o        = rsp_valid_q;
  assign rsp_granted_o      = rsp_granted_q;
  assign rsp_granted_slot_o = rsp_slot_q;
  assign rsp_stole_o        = rsp_stole_q;
  assign rsp_live_count_o   = rsp_live_q;
  assign rsp_any_ducking_o  = rsp_duck_q;
  assign rsp_drop_total_o   = rsp_drop_q;
  assign rsp_steal_total_o  = rsp_steal_q;

endmodule

// ===== rtl/core/priority_voice_allocator_top.sv =====
// ----------------------------------------------------------------------------
// priority_voice_allocator_top
// Voice slot allocator with priority-based stealing, one result per event.
// ----------------------------------------------------------------------------
// For each event item, between acceptance and the result showing on rsp_o,
// the slot table is read one entry per cycle through its single read port
// to find the first free slot, the steal victim or the voices to fade,
// followed by a commit step and a publish step that waits for the output
// register to be free. The next item is accepted only after the publish,
// while the previous result may still wait in the output register.
// ----------------------------------------------------------------------------
module priority_voice_allocator_top #(
  parameter int unsigned VOICE_SLOTS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pva_req_if.sink  req_i,
  pva_rsp_if.source rsp_o
);
  import pva_pkg::*;

  pva_cmd_t cmd;
  pva_sts_t sts;

  pva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pva_datapath #(
    .VOICE_SLOTS (VOICE_SLOTS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .req_action_i       (req_i.action),
    .req_sound_id_i     (req_i.sound_id),
    .req_priority_i     (req_i.priority_req),
    .req_playable_i     (req_i.playable),
    .req_music_duck_i   (req_i.music_duck),
    .req_slot_i         (req_i.slot),
    .rsp_ready_i        (rsp_o.ready),
    .rsp_valid_o        (rsp_o.valid),
    .rsp_granted_o      (rsp_o.granted),
    .rsp_granted_slot_o (rsp_o.granted_slot),
    .rsp_stole_o        (rsp_o.stole),
    .rsp_live_count_o   (rsp_o.live_count),
    .rsp_any_ducking_o  (rsp_o.any_ducking),
    .rsp_drop_total_o   (rsp_o.drop_total),
    .rsp_steal_total_o  (rsp_o.steal_total)
  );

endmodule

// ===== rtl/core/pva_checker.sv =====
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks for the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pva_checker #(
  parameter int unsigned VOICE_SLOTS = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic                             rsp_granted_i,
  input logic [pva_pkg::SLOT_FIELD_W-1:0] rsp_granted_slot_i,
  input logic                             rsp_stole_i,
  input logic [pva_pkg::LIVE_FIELD_W-1:0] rsp_live_count_i
);
  import pva_pkg::*;

  logic req_acc;
  logic rsp_stall;

  assign req_acc   = req_valid_i && req_ready_i;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;

  // result stays offered until taken
  `PVA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i)

  // one item in flight: ready drops right after an accept
  `PVA_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, req_acc, !req_ready_i)

  // no grant means no slot and no steal
  `PVA_ASSERT_IMP(a_no_grant_fields, clk_i, rst_ni, rsp_valid_i && !rsp_granted_i, (rsp_granted_slot_i == '0) && !rsp_stole_i)

  // live count never exceeds the slot count
  `PVA_ASSERT_IMP(a_live_bound, clk_i, rst_ni, rsp_valid_i, 32'(rsp_live_count_i) <= VOICE_SLOTS)

endmodule

bind priority_voice_allocator_top pva_checker #(
  .VOICE_SLOTS (VOICE_SLOTS)
) u_pva_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_granted_i      (rsp_o.granted),
  .rsp_granted_slot_i (rsp_o.granted_slot),
  .rsp_stole_i        (rsp_o.stole),
  .rsp_live_count_i   (rsp_o.live_count)
);

// ===== bench/priority_voice_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// priority_voice_allocator_top_tb
// Self-checking bench for the voice slot allocator. Voice events go in on the
// request channel. A local mirror of the slot table predicts each result:
// first free slot, steal of the lowest priority oldest voice, drops, fades,
// frees and the wrapping totals. Results are checked in order. Both channels
// idle at random, and some stretches run with no idling at all.
// ----------------------------------------------------------------------------
module priority_voice_allocator_top_tb;
  import pva_pkg::*;

  localparam int NSLOTS = 16;
  localparam int SETTLE = 40;
  localparam int LIMIT  = 1_000_000;

  typedef struct packed {
    logic                    granted;
    logic [SLOT_FIELD_W-1:0] granted_slot;
    logic                    stole;
    logic [LIVE_FIELD_W-1:0] live_count;
    logic                    any_ducking;
    logic [TOTAL_W-1:0]      drop_total;
    logic [TOTAL_W-1:0]      steal_total;
  } alloc_result_t;

  logic clk;
  logic rst_n;

  pva_req_if req ();
  pva_rsp_if rsp ();

  priority_voice_allocator_top #(
    .VOICE_SLOTS(NSLOTS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // mirror of the voice table
  bit                 voice_live   [NSLOTS];
  logic [SOUND_W-1:0] voice_sound  [NSLOTS];
  logic [PRIO_W-1:0]  voice_prio   [NSLOTS];
  logic [AGE_W-1:0]   voice_age    [NSLOTS];
  bit                 voice_fading [NSLOTS];
  bit                 voice_ducks  [NSLOTS];
  logic [AGE_W-1:0]   start_cnt = '0;
  logic [TOTAL_W-1:0] drop_cnt  = '0;
  logic [TOTAL_W-1:0] steal_cnt = '0;

  alloc_result_t expected_allocs[$];
  int            mismatches = 0;
  bit            idle_en    = 1'b0;
  int            cycle_cnt  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic alloc_result_t apply_voice_event(action_e act,
      logic [SOUND_W-1:0] snd, logic [PRIO_W-1:0] pr, logic play, logic dk,
      logic [SLOT_FIELD_W-1:0] fin);
    alloc_result_t r;
    int            pick;
    int            live_n;
    r      = '0;
    pick   = -1;
    live_n = 0;
    case (act)
      ACT_START: begin
        if (play) begin
          for (int i = 0; i < NSLOTS && pick < 0; i++)
            if (!voice_live[i]) pick = i;
          if (pick < 0) begin
            for (int i = 0; i < NSLOTS; i++) begin
              if (voice_prio[i] <= pr &&
                  (pick < 0 || voice_prio[i] < voice_prio[pick] ||
                   (voice_prio[i] == voice_prio[pick] &&
                    voice_age[i] < voice_age[pick])))
                pick = i;
            end
          end
        end
        if (pick < 0) begin
          drop_cnt++;
        end else begin
          if (voice_live[pick]) begin
            r.stole = 1'b1;
            steal_cnt++;
          end
          start_cnt++;
          voice_live[pick]   = 1'b1;
          voice_sound[pick]  = snd;
          voice_prio[pick]   = pr;
          voice_age[pick]    = start_cnt;
          voice_fading[pick] = 1'b0;
          voice_ducks[pick]  = dk;
          r.granted          = 1'b1;
          r.granted_slot     = SLOT_FIELD_W'(pick);
        end
      end
      ACT_STOP: begin
        for (int i = 0; i < NSLOTS; i++)
          if (voice_live[i] && voice_sound[i] == snd) voice_fading[i] = 1'b1;
      end
      ACT_STOP_ALL: begin
        for (int i = 0; i < NSLOTS; i++)
          if (voice_live[i]) voice_fading[i] = 1'b1;
      end
      default: begin
        if (int'(fin) < NSLOTS) begin
          voice_live[fin]   = 1'b0;
          voice_fading[fin] = 1'b0;
          voice_ducks[fin]  = 1'b0;
        end
      end
    endcase
    for (int i = 0; i < NSLOTS; i++) begin
      if (voice_live[i]) begin
        live_n++;
        if (!voice_fading[i] && voice_ducks[i]) r.any_ducking = 1'b1;
      end
    end
    r.live_count  = LIVE_FIELD_W'(live_n);
    r.drop_total  = drop_cnt;
    r.steal_total = steal_cnt;
    return r;
  endfunction

  function automatic string fmt_alloc(alloc_result_t r);
    return $sformatf("granted=%0d slot=%0d stole=%0d live=%0d duck=%0d drops=%0d steals=%0d",
                     r.granted, r.granted_slot, r.stole, r.live_count,
                     r.any_ducking, r.drop_total, r.steal_total);
  endfunction

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_cnt, what);
  endfunction

  // mostly short, a few long
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // result sink: checks each accepted result and stalls at random
  initial begin
    int            stall_left;
    alloc_result_t got;
    alloc_result_t want;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp.valid && rsp.ready) begin
        got = {rsp.granted, rsp.granted_slot, rsp.stole, rsp.live_count,
               rsp.any_ducking, rsp.drop_total, rsp.steal_total};
        if (expected_allocs.size() == 0) begin
          report_mismatch({"unexpected result: ", fmt_alloc(got)});
        end else begin
          want = expected_allocs.pop_front();
          if (got !== want)
            report_mismatch({"expected ", fmt_alloc(want), " actual ", fmt_alloc(got)});
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 99) < 20) begin
        stall_left = idle_len() - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_event(action_e act, logic [SOUND_W-1:0] snd,
      logic [PRIO_W-1:0] pr, logic play, logic dk, logic [SLOT_FIELD_W-1:0] fin);
    int gap;
    gap = (idle_en && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.sound_id     <= snd;
    req.priority_req <= pr;
    req.playable     <= play;
    req.music_duck   <= dk;
    req.slot         <= fin;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_allocs.push_back(apply_voice_event(act, snd, pr, play, dk, fin));
  endtask

  function automatic logic [SOUND_W-1:0] pick_sound();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8001;
      3:       return 16'h7FFE;
      4:       return 16'h1234;
      5:       return 16'hA5A5;
      default: return SOUND_W'($urandom());
    endcase
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return PRIO_W'($urandom_range(0, 7));
    if (r < 50) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return PRIO_W'($urandom());
  endfunction

  // well-formed event against the current table, random content
  task automatic send_voice_event(int start_pct);
    int                      r;
    int                      live_idx[$];
    logic [SOUND_W-1:0]      snd;
    logic [SLOT_FIELD_W-1:0] fin;
    r   = $urandom_range(0, 99);
    snd = pick_sound();
    fin = SLOT_FIELD_W'($urandom());
    for (int i = 0; i < NSLOTS; i++)
      if (voice_live[i]) live_idx.push_back(i);
    if (r < start_pct) begin
      send_event(ACT_START, snd, pick_prio(), $urandom_range(0, 9) != 0,
                 1'($urandom_range(0, 1)), fin);
    end else begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        if (live_idx.size() > 0 && $urandom_range(0, 9) != 0)
          fin = SLOT_FIELD_W'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
        send_event(ACT_FINISH, pick_sound(), pick_prio(), 1'($urandom()),
                   1'($urandom()), fin);
      end else if (r < 9) begin
        if (live_idx.size() > 0 && $urandom_range(0, 4) != 0)
          snd = voice_sound[live_idx[$urandom_range(0, live_idx.size() - 1)]];
        send_event(ACT_STOP, snd, pick_prio(), 1'($urandom()), 1'($urandom()), fin);
      end else begin
        send_event(ACT_STOP_ALL, snd, pick_prio(), 1'($urandom()), 1'($urandom()), fin);
      end
    end
  endtask

  task automatic test_directed();
    // nothing live yet: stop-all and stop change nothing
    send_event(ACT_STOP_ALL, 16'h0000, 8'h00, 1'b0, 1'b0, 4'h0);
    send_event(ACT_STOP, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 4'hF);
    for (int i = 0; i < NSLOTS; i++)
      send_event(ACT_START, (i % 2) ? 16'hFFFF : 16'h0000,
                 (i == 0) ? 8'hFF : ((i % 4 == 0) ? 8'd1 : PRIO_W'(100 + i)),
                 1'b1, (i % 3 == 0), 4'h0);
    // full table, every voice above the request
    send_event(ACT_START, 16'h1234, 8'h00, 1'b1, 1'b1, 4'h0);
    // equal priority: oldest goes first
    send_event(ACT_START, 16'h1234, 8'd1, 1'b1, 1'b0, 4'h0);
    send_event(ACT_START, 16'h1234, 8'd1, 1'b1, 1'b1, 4'h0);
    send_event(ACT_STOP, 16'hFFFF, 8'h00, 1'b0, 1'b0, 4'h0);
    send_event(ACT_STOP_ALL, 16'h0000, 8'h00, 1'b0, 1'b0, 4'h0);
    send_event(ACT_FINISH, 16'h0000, 8'h00, 1'b0, 1'b0, 4'hF);
    send_event(ACT_FINISH, 16'h0000, 8'h00, 1'b0, 1'b0, 4'hF);
    send_event(ACT_START, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 4'h0);
    send_event(ACT_START, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 4'hF);
  endtask

  task automatic test_noise(int n);
    repeat (n)
      send_event(action_e'($urandom_range(0, 3)), SOUND_W'($urandom()),
                 PRIO_W'($urandom()), 1'($urandom()), 1'($urandom()),
                 SLOT_FIELD_W'($urandom()));
  endtask

  task automatic test_voice_churn(int n);
    repeat (n) send_voice_event(55);
  endtask

  task automatic test_steal_storm(int n);
    repeat (n) send_voice_event(85);
  endtask

  task automatic test_drain_pauses(int bursts, int len);
    repeat (bursts) begin
      repeat (len) send_voice_event(60);
      req.valid <= 1'b0;
      wait (expected_allocs.size() == 0);
      @(posedge clk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    req.valid        <= 1'b0;
    req.action       <= ACT_START;
    req.sound_id     <= '0;
    req.priority_req <= '0;
    req.playable     <= 1'b0;
    req.music_duck   <= 1'b0;
    req.slot         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    idle_en = 1'b1;
    test_directed();
    test_noise(200);
    test_voice_churn(1000);
    idle_en = 1'b0;
    test_steal_storm(280);
    test_drain_pauses(6, 25);

    req.valid <= 1'b0;
    wait (expected_allocs.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_allocs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pva_pkg.sv
rtl/core/pva_req_if.sv
rtl/core/pva_rsp_if.sv
rtl/core/pva_ctrl.sv
rtl/core/pva_datapath.sv
rtl/core/priority_voice_allocator_top.sv
rtl/core/pva_checker.sv
bench/priority_voice_allocator_top_tb.sv
